// ===== design/lpc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types and codes for the LRU page cache tag store.
// ----------------------------------------------------------------------------
package lpc_pkg;

   localparam int CmdW  = 3;
   localparam int StatW = 2;
   localparam int CapW  = 5;
   localparam logic [CapW-1:0] CAP_RESET = 5'd16;

   // request commands
   localparam logic [CmdW-1:0] CMD_CLEAN_INS   = 3'd0;
   localparam logic [CmdW-1:0] CMD_DIRTY_INS   = 3'd1;
   localparam logic [CmdW-1:0] CMD_PARTIAL_INS = 3'd2;
   localparam logic [CmdW-1:0] CMD_LOOKUP      = 3'd3;
   localparam logic [CmdW-1:0] CMD_REMOVE      = 3'd4;
   localparam logic [CmdW-1:0] CMD_EXISTS      = 3'd5;

   // response status
   localparam logic [StatW-1:0] ST_OK   = 2'd0;
   localparam logic [StatW-1:0] ST_MISS = 2'd1;
   localparam logic [StatW-1:0] ST_BAD  = 2'd2;

   // datapath operations
   localparam logic [2:0] OP_NONE    = 3'd0;
   localparam logic [2:0] OP_TOUCH   = 3'd1;
   localparam logic [2:0] OP_PARTIAL = 3'd2;
   localparam logic [2:0] OP_DROP    = 3'd3;
   localparam logic [2:0] OP_EVICT   = 3'd4;
   localparam logic [2:0] OP_ADD     = 3'd5;

   typedef struct packed {
      logic [CmdW-1:0] cmd;
      logic [15:0]     file_id;
      logic [31:0]     page_number;
   } req_type;

   typedef struct packed {
      logic [StatW-1:0] status;
      logic             clean_present;
      logic             dirty_present;
      logic             evicted;
      logic [15:0]      evicted_file_id;
      logic [31:0]      evicted_page_number;
      logic             evicted_dirty;
   } rsp_type;

   typedef struct packed {
      logic             take;
      logic [2:0]       op;
      logic             add_dirty;
      logic             load;
      logic [StatW-1:0] status;
   } dp_cmd_type;

   typedef struct packed {
      logic hit;
      logic room;
      logic over;
   } dp_sts_type;

endpackage

// ===== design/lpc_datapath.sv =====
// ----------------------------------------------------------------------------
// lpc_datapath
// Slot tags, copy bits, LRU ranks, copy count and the response register.
// ----------------------------------------------------------------------------
module lpc_datapath #(
   parameter int SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lpc_pkg::req_type      req_data,
   input  logic                  csr_we,
   input  logic [lpc_pkg::CapW-1:0] csr_wdata,
   input  lpc_pkg::dp_cmd_type   cmd,
   output lpc_pkg::dp_sts_type   sts,
   output lpc_pkg::rsp_type      rsp_data
);

   localparam int AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int UW   = $clog2(SLOTS + 1);
   localparam int CW   = $clog2(2 * SLOTS + 1);
   localparam int CMPW = (CW > lpc_pkg::CapW) ? CW : lpc_pkg::CapW;

   logic [15:0]  key_file_ff;
   logic [31:0]  key_page_ff;
   logic [15:0]  slot_file_ff [SLOTS];
   logic [31:0]  slot_page_ff [SLOTS];
   logic [SLOTS-1:0] clean_ff, clean_in, dirty_ff, dirty_in;
   logic [AW-1:0] age_ff [SLOTS];
   logic [AW-1:0] age_in [SLOTS];
   logic [CW-1:0] copies_ff, copies_in;
   logic [UW-1:0] used_ff, used_in;
   logic [lpc_pkg::CapW-1:0] cap_ff;

   logic          ev_ff;
   logic [15:0]   ev_file_ff;
   logic [31:0]   ev_page_ff;
   logic          ev_dirty_ff;
   lpc_pkg::rsp_type rsp_ff;

   logic [SLOTS-1:0] valid, hit_vec, free_vec, old_vec, sel_vec;
   logic [AW-1:0]    hit_idx, free_idx, old_idx, sel_idx;
   logic [AW-1:0]    sel_age, old_rank;
   logic [CMPW-1:0]  cap_eff;

   assign valid    = clean_ff | dirty_ff;
   assign old_rank = AW'(used_ff - UW'(1));

   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      old_idx  = '0;
      for (int i = 0; i < SLOTS; i++) begin
         hit_vec[i]  = valid[i] && slot_file_ff[i] == key_file_ff
                       && slot_page_ff[i] == key_page_ff;
         free_vec[i] = !valid[i];
         old_vec[i]  = valid[i] && age_ff[i] == old_rank;
      end
      // lowest index wins
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (hit_vec[i]) hit_idx = AW'(i);
         if (free_vec[i]) free_idx = AW'(i);
         if (old_vec[i]) old_idx = AW'(i);
      end
   end

   assign sel_vec = (cmd.op == lpc_pkg::OP_EVICT) ? old_vec : hit_vec;
   assign sel_idx = (cmd.op == lpc_pkg::OP_EVICT) ? old_idx : hit_idx;
   assign sel_age = age_ff[sel_idx];

   assign cap_eff  = (cap_ff == '0) ? CMPW'(1) : CMPW'(cap_ff);
   assign sts.hit  = |hit_vec;
   assign sts.room = |free_vec;
   assign sts.over = CMPW'(copies_ff) > cap_eff;

   always_comb begin
      clean_in  = clean_ff;
      dirty_in  = dirty_ff;
      age_in    = age_ff;
      copies_in = copies_ff;
      used_in   = used_ff;
      case (cmd.op)
         lpc_pkg::OP_TOUCH, lpc_pkg::OP_PARTIAL: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (valid[i] && !sel_vec[i] && age_ff[i] < sel_age)
                  age_in[i] = age_ff[i] + AW'(1);
            end
            age_in[sel_idx] = '0;
            if (cmd.op == lpc_pkg::OP_PARTIAL && !dirty_ff[sel_idx]) begin
               dirty_in[sel_idx] = 1'b1;
               copies_in = copies_ff + CW'(1);
            end
         end
         lpc_pkg::OP_DROP, lpc_pkg::OP_EVICT: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (valid[i] && !sel_vec[i] && age_ff[i] > sel_age)
                  age_in[i] = age_ff[i] - AW'(1);
            end
            age_in[sel_idx]   = '0;
            clean_in[sel_idx] = 1'b0;
            dirty_in[sel_idx] = 1'b0;
            copies_in = copies_ff - CW'(clean_ff[sel_idx]) - CW'(dirty_ff[sel_idx]);
            used_in   = used_ff - UW'(1);
         end
         lpc_pkg::OP_ADD: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (valid[i]) age_in[i] = age_ff[i] + AW'(1);
            end
            age_in[free_idx]   = '0;
            clean_in[free_idx] = !cmd.add_dirty;
            dirty_in[free_idx] = cmd.add_dirty;
            copies_in = copies_ff + CW'(1);
            used_in   = used_ff + UW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clean_ff  <= '0;
         dirty_ff  <= '0;
         copies_ff <= '0;
         used_ff   <= '0;
         cap_ff    <= lpc_pkg::CAP_RESET;
         for (int i = 0; i < SLOTS; i++) age_ff[i] <= '0;
      end else begin
         clean_ff  <= clean_in;
         dirty_ff  <= dirty_in;
         age_ff    <= age_in;
         copies_ff <= copies_in;
         used_ff   <= used_in;
         if (csr_we) cap_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         key_file_ff <= req_data.file_id;
         key_page_ff <= req_data.page_number;
         ev_ff       <= 1'b0;
         ev_file_ff  <= '0;
         ev_page_ff  <= '0;
         ev_dirty_ff <= 1'b0;
      end else if (cmd.op == lpc_pkg::OP_EVICT) begin
         ev_ff       <= 1'b1;
         ev_file_ff  <= slot_file_ff[old_idx];
         ev_page_ff  <= slot_page_ff[old_idx];
         ev_dirty_ff <= dirty_ff[old_idx];
      end
      if (cmd.op == lpc_pkg::OP_ADD) begin
         slot_file_ff[free_idx] <= key_file_ff;
         slot_page_ff[free_idx] <= key_page_ff;
      end
      if (cmd.load) begin
         rsp_ff.status              <= cmd.status;
         rsp_ff.clean_present       <= sts.hit && clean_ff[hit_idx];
         rsp_ff.dirty_present       <= sts.hit && dirty_ff[hit_idx];
         rsp_ff.evicted             <= ev_ff;
         rsp_ff.evicted_file_id     <= ev_file_ff;
         rsp_ff.evicted_page_number <= ev_page_ff;
         rsp_ff.evicted_dirty       <= ev_dirty_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== design/lpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpc_ctrl
// Command sequencer: steps one request through touch, partial, drop, evict and add.
// ----------------------------------------------------------------------------
module lpc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [lpc_pkg::CmdW-1:0] req_cmd,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  lpc_pkg::dp_sts_type sts,
   output lpc_pkg::dp_cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_ROOM   = 3'd2;
   localparam logic [2:0] S_ADD    = 3'd3;
   localparam logic [2:0] S_CAP    = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0] st_ff, st_in;
   logic [lpc_pkg::CmdW-1:0] cmd_ff;
   logic [lpc_pkg::StatW-1:0] code_ff, code_in;
   logic evd_ff, evd_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_ready = (st_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      st_in         = st_ff;
      code_in       = code_ff;
      evd_in        = evd_ff;
      cmd           = '0;
      cmd.take      = accept;
      cmd.add_dirty = (cmd_ff == lpc_pkg::CMD_DIRTY_INS);
      cmd.status    = code_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      case (st_ff)
         S_IDLE: begin
            if (accept) begin
               st_in  = S_DECIDE;
               evd_in = 1'b0;
            end
         end
         S_DECIDE: begin
            code_in = lpc_pkg::ST_OK;
            st_in   = S_DONE;
            case (cmd_ff)
               lpc_pkg::CMD_CLEAN_INS: begin
                  if (sts.hit) begin
                     cmd.op = lpc_pkg::OP_TOUCH;
                     st_in  = S_CAP;
                  end else begin
                     st_in = S_ROOM;
                  end
               end
               lpc_pkg::CMD_DIRTY_INS: begin
                  if (sts.hit) cmd.op = lpc_pkg::OP_DROP;
                  st_in = S_ROOM;
               end
               lpc_pkg::CMD_PARTIAL_INS: begin
                  if (sts.hit) begin
                     cmd.op = lpc_pkg::OP_PARTIAL;
                     st_in  = S_CAP;
                  end else begin
                     code_in = lpc_pkg::ST_BAD;
                  end
               end
               lpc_pkg::CMD_LOOKUP: begin
                  if (sts.hit) cmd.op = lpc_pkg::OP_TOUCH;
                  else code_in = lpc_pkg::ST_MISS;
               end
               lpc_pkg::CMD_REMOVE: begin
                  if (sts.hit) cmd.op = lpc_pkg::OP_DROP;
                  else code_in = lpc_pkg::ST_MISS;
               end
               lpc_pkg::CMD_EXISTS: begin
                  if (!sts.hit) code_in = lpc_pkg::ST_MISS;
               end
               default: code_in = lpc_pkg::ST_BAD;
            endcase
         end
         S_ROOM: begin
            // all slots taken: evict the oldest key to make room
            if (!sts.room) begin
               cmd.op = lpc_pkg::OP_EVICT;
               evd_in = 1'b1;
            end
            st_in = S_ADD;
         end
         S_ADD: begin
            cmd.op = lpc_pkg::OP_ADD;
            st_in  = S_CAP;
         end
         S_CAP: begin
            if (!evd_ff && sts.over) cmd.op = lpc_pkg::OP_EVICT;
            st_in = S_DONE;
         end
         S_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               st_in        = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         code_ff      <= lpc_pkg::ST_OK;
         evd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         code_ff      <= code_in;
         evd_ff       <= evd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) cmd_ff <= req_cmd;
   end

`ifndef SYNTHESIS
   a_accept_decide: assert property (@(posedge clock) disable iff (reset)
      accept |=> st_ff == S_DECIDE)
      else $error("accepted request did not reach decide");
   a_cap_done: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_CAP |=> st_ff == S_DONE)
      else $error("capacity check did not finish");
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_valid_ff && st_ff == S_IDLE)
      else $error("response load lost");
   a_one_evict_room: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_CAP && evd_ff |-> cmd.op != lpc_pkg::OP_EVICT)
      else $error("second eviction in one command");
`endif

endmodule

// ===== design/lru_page_cache_clean_dirty_pairs_core.sv =====
// ----------------------------------------------------------------------------
// lru_page_cache_clean_dirty_pairs_core
// Fully associative LRU tag store with clean and dirty copies per page key.
// ----------------------------------------------------------------------------
// Sequence: lookup, remove, exists and rejected commands pass decide and done;
//   refresh inserts and partial inserts pass decide, capacity check and done;
//   dirty inserts and inserts of a new key pass decide, room, add, capacity
//   check and done. Requests: one at a time; the next beat is taken the cycle
//   after the response loads, and the load waits while an earlier response
//   still waits for rsp_ready.
// Reset: synchronous; clears all copy bits, LRU ranks and the copy count,
//   sets capacity to 16. Slot tags are not reset.
// ----------------------------------------------------------------------------
module lru_page_cache_clean_dirty_pairs_core #(
   parameter int SLOTS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  lpc_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output lpc_pkg::rsp_type           rsp_data,
   input  logic                       csr_we,
   input  logic [lpc_pkg::CapW-1:0]   csr_wdata
);

   // command and status between sequencer and slot datapath
   lpc_pkg::dp_cmd_type dp_cmd;
   lpc_pkg::dp_sts_type dp_sts;

   lpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_data.cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (dp_sts),
      .cmd       (dp_cmd)
   );

   // slot tags, copy bits, ranks and the response register
   lpc_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (dp_cmd),
      .sts       (dp_sts),
      .rsp_data  (rsp_data)
   );

endmodule
